// File: rtl/acfp_pkg.sv
// shared types and constants for the activation frame port checker
`default_nettype none

package acfp_pkg;

   // default table size and front-to-back queue depth
   localparam int TABLE_DEPTH_DEF = 4096;
   localparam int QUEUE_DEPTH     = 4;

   // port event codes
   localparam logic [3:0] FUNC_ORIGIN   = 4'd0;
   localparam logic [3:0] FUNC_ALPHA    = 4'd1;
   localparam logic [3:0] FUNC_BETA     = 4'd2;
   localparam logic [3:0] FUNC_OMEGA    = 4'd3;
   localparam logic [3:0] FUNC_GAMMA    = 4'd4;
   localparam logic [3:0] FUNC_FL_ALPHA = 4'd5;
   localparam logic [3:0] FUNC_FL_GAMMA = 4'd8;

   // frameless codes sit this far above their framed counterparts
   localparam logic [3:0] FL_OFFSET = 4'd4;

   // expected frame of a framed alpha lies this far below its stack pointer
   localparam logic [47:0] FRAME_OFFSET = 48'd8;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   // activation phase of a table entry
   typedef enum logic [2:0] {
      PH_FRESH   = 3'd0,
      PH_LIVE    = 3'd1,
      PH_SUSP    = 3'd2,
      PH_RESUMED = 3'd3,
      PH_DEAD    = 3'd4
   } phase_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   // one port event
   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] node;
      logic [47:0] frame_pointer;
      logic [47:0] stack_pointer;
   } item_type;

   // one activation table entry
   typedef struct packed {
      logic [31:0] tag;
      logic [47:0] enclosing_frame;
      logic [47:0] expected_frame;
      logic [47:0] alpha_stack;
      logic        live;
      phase_type   phase;
   } entry_type;

   // one check result
   typedef struct packed {
      logic               no_alpha;
      logic               illegal;
      logic               frame_lost;
      logic               stack_leak;
      logic               overpop;
      logic               alpha_while_live;
      logic               fatal;
      logic signed [47:0] frame_skew;
      logic signed [47:0] depth;
      phase_type          prior_phase;
      logic [31:0]        violation_total;
      logic [31:0]        illegal_total;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/acfp_front.sv
// front end: accepts port events and computes the table index
`default_nettype none

module acfp_front #(
   parameter int TABLE_DEPTH = acfp_pkg::TABLE_DEPTH_DEF,
   localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     enable,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire acfp_pkg::item_type req_item,
   output logic                    out_valid,
   input  wire                     out_ready,
   output acfp_pkg::item_type      out_item,
   output logic [IDX_W-1:0]        out_idx
);

   localparam int          IW1     = IDX_W + 1;
   localparam logic [31:0] RECIP   = 32'((64'h1_0000_0000) / 64'(TABLE_DEPTH));
   localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
   localparam logic [IDX_W:0] DEPTH_C = IW1'(TABLE_DEPTH);

   logic               s1_valid_ff;
   logic               s1_valid_in;
   acfp_pkg::item_type s1_item_ff;
   logic [63:0]        s1_prod_ff;
   logic               s2_valid_ff;
   logic               s2_valid_in;
   acfp_pkg::item_type s2_item_ff;
   logic [IDX_W:0]     s2_rem_ff;
   logic [IDX_W:0]     s2_rem_in;
   logic [31:0]        quot;
   logic [31:0]        quot_times_depth;
   logic [31:0]        rem_full;
   logic               s2_load;
   logic               s1_load;

   // stage handshakes
   assign s2_load   = !s2_valid_ff || out_ready;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_ready = enable && s1_load;

   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   // reciprocal estimate of node / depth, low by at most one
   assign quot             = s1_prod_ff[63:32];
   assign quot_times_depth = quot * DEPTH32;
   assign rem_full         = s1_item_ff.node - quot_times_depth;
   assign s2_rem_in        = rem_full[IDX_W:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // stage one: capture and multiply by the reciprocal
   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_item_ff <= req_item;
         s1_prod_ff <= 64'(req_item.node) * 64'(RECIP);
      end
   end

   // stage two: remainder before correction
   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_item_ff <= s1_item_ff;
         s2_rem_ff  <= s2_rem_in;
      end
   end

   // final correction of the remainder
   always_comb begin
      out_valid = s2_valid_ff;
      out_item  = s2_item_ff;
      if (s2_rem_ff >= DEPTH_C) begin
         out_idx = IDX_W'(s2_rem_ff - DEPTH_C);
      end else begin
         out_idx = s2_rem_ff[IDX_W-1:0];
      end
   end

   // index always lands inside the table
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (32'(out_idx) < DEPTH32))
      else $error("front index out of range");

   // stalled stage two keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_ready) |=> (s2_valid_ff && $stable(s2_item_ff)))
      else $error("front stage two lost a stalled transaction");

   // nothing enters while the table is not available
   assert property (@(posedge clock) disable iff (reset)
      !enable |-> !req_ready)
      else $error("front accepted while disabled");

endmodule

`default_nettype wire

// File: rtl/acfp_queue.sv
// small fifo between the front and back ends
`default_nettype none

module acfp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = acfp_pkg::QUEUE_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_ready,
   input  wire [WIDTH-1:0]  in_data,
   output logic             out_valid,
   input  wire              out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != CNT_FULL;
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   // fill count stays within the storage
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count overflow");

   // a lone pop shrinks the fill count by one
   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count lost a pop");

   // equal pointers mean empty or full
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) |-> (count_ff == '0 || count_ff == CNT_FULL))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: rtl/acfp_back.sv
// back end: activation table read-modify-write, checks and result register
`default_nettype none

module acfp_back #(
   parameter int TABLE_DEPTH = acfp_pkg::TABLE_DEPTH_DEF,
   localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_wr_en,
   input  wire                     csr_wr_data,
   output logic                    table_ready,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  wire acfp_pkg::item_type in_item,
   input  wire [IDX_W-1:0]         in_idx,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output acfp_pkg::rsp_type       rsp
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

   acfp_pkg::entry_type      table_mem [TABLE_DEPTH];
   acfp_pkg::entry_type      rd_data_ff;
   acfp_pkg::back_state_type state_ff;
   acfp_pkg::back_state_type state_in;
   logic [IDX_W-1:0]         clr_addr_ff;
   logic [IDX_W-1:0]         clr_addr_in;
   acfp_pkg::item_type       cur_item_ff;
   logic [IDX_W-1:0]         cur_idx_ff;
   logic                     ovp_en_ff;
   logic [47:0]              origin_ff;
   logic [47:0]              origin_in;
   logic [31:0]              viol_cnt_ff;
   logic [31:0]              viol_cnt_in;
   logic [31:0]              ill_cnt_ff;
   logic [31:0]              ill_cnt_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   acfp_pkg::rsp_type        rsp_ff;
   acfp_pkg::rsp_type        res;

   logic                     clearing;
   logic                     exec_wait;
   logic                     pop;
   logic                     exec_fire;
   logic                     upd;
   acfp_pkg::entry_type      new_ent;
   logic                     tbl_we;
   logic [IDX_W-1:0]         tbl_waddr;
   acfp_pkg::entry_type      tbl_wdata;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acfp_pkg::BK_CLEAR: begin
            if (clr_addr_ff == IDX_LAST) begin
               state_in = acfp_pkg::BK_IDLE;
            end
         end
         acfp_pkg::BK_IDLE: begin
            if (in_valid) begin
               state_in = acfp_pkg::BK_EXEC;
            end
         end
         acfp_pkg::BK_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = acfp_pkg::BK_IDLE;
            end
         end
         default: state_in = acfp_pkg::BK_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      clearing  = 1'b0;
      in_ready  = 1'b0;
      exec_wait = 1'b0;
      case (state_ff)
         acfp_pkg::BK_CLEAR: clearing  = 1'b1;
         acfp_pkg::BK_IDLE:  in_ready  = 1'b1;
         acfp_pkg::BK_EXEC:  exec_wait = 1'b1;
         default:            clearing  = 1'b0;
      endcase
   end

   assign table_ready = !clearing;
   assign pop         = in_ready && in_valid;
   assign exec_fire   = exec_wait && (!rsp_valid_ff || rsp_ready);
   assign clr_addr_in = clearing ? clr_addr_ff + 1'b1 : clr_addr_ff;

   // checks and entry update for the current transaction
   always_comb begin
      logic                fl;
      logic [3:0]          kind;
      logic                owned;
      acfp_pkg::entry_type ent;
      logic [47:0]         fp;
      logic [47:0]         sp;
      logic [47:0]         ref_frame;
      logic [31:0]         viol_step;

      fl   = cur_item_ff.func inside {[acfp_pkg::FUNC_FL_ALPHA:acfp_pkg::FUNC_FL_GAMMA]};
      kind = fl ? cur_item_ff.func - acfp_pkg::FL_OFFSET : cur_item_ff.func;
      ent  = rd_data_ff;
      fp   = cur_item_ff.frame_pointer;
      sp   = cur_item_ff.stack_pointer;
      owned     = ent.tag == cur_item_ff.node;
      ref_frame = (kind == acfp_pkg::FUNC_OMEGA) ? ent.enclosing_frame : ent.expected_frame;

      res             = '0;
      res.prior_phase = owned ? ent.phase : acfp_pkg::PH_FRESH;
      res.depth       = (origin_ff != '0) ? origin_ff - sp : '0;
      new_ent         = ent;
      upd             = 1'b0;
      origin_in       = origin_ff;

      case (kind)
         acfp_pkg::FUNC_ORIGIN: begin
            origin_in = sp;
         end
         acfp_pkg::FUNC_ALPHA: begin
            res.alpha_while_live = owned && (ent.phase == acfp_pkg::PH_LIVE ||
               ent.phase == acfp_pkg::PH_SUSP || ent.phase == acfp_pkg::PH_RESUMED);
            new_ent.tag             = cur_item_ff.node;
            new_ent.enclosing_frame = fp;
            new_ent.expected_frame  = fl ? fp : sp - acfp_pkg::FRAME_OFFSET;
            new_ent.alpha_stack     = sp;
            new_ent.live            = 1'b1;
            new_ent.phase           = acfp_pkg::PH_LIVE;
            upd                     = 1'b1;
         end
         acfp_pkg::FUNC_BETA, acfp_pkg::FUNC_OMEGA, acfp_pkg::FUNC_GAMMA: begin
            if (!owned || !ent.live) begin
               // no live activation: slot untouched
               res.no_alpha = kind == acfp_pkg::FUNC_BETA;
               if (kind == acfp_pkg::FUNC_GAMMA && (!owned ||
                   ent.phase == acfp_pkg::PH_FRESH || ent.phase == acfp_pkg::PH_DEAD)) begin
                  res.illegal = 1'b1;
                  res.fatal   = !fl;
               end
            end else begin
               res.frame_skew = fp - ref_frame;
               res.frame_lost = fp != ref_frame;
               if (kind == acfp_pkg::FUNC_BETA) begin
                  res.illegal   = ent.phase != acfp_pkg::PH_SUSP;
                  res.fatal     = (res.illegal && !fl) || res.frame_lost;
                  new_ent.phase = acfp_pkg::PH_RESUMED;
               end else if (kind == acfp_pkg::FUNC_GAMMA) begin
                  res.illegal   = ent.phase != acfp_pkg::PH_LIVE &&
                                  ent.phase != acfp_pkg::PH_RESUMED;
                  res.fatal     = (res.illegal || res.frame_lost) && !fl;
                  new_ent.phase = acfp_pkg::PH_SUSP;
               end else begin
                  res.overpop    = ovp_en_ff && (sp > ent.alpha_stack);
                  res.stack_leak = sp < ent.alpha_stack;
                  res.fatal      = (res.frame_lost || res.stack_leak) && !fl;
                  new_ent.live   = 1'b0;
                  new_ent.phase  = acfp_pkg::PH_DEAD;
               end
               upd = !res.fatal;
            end
         end
         default: begin
            upd = 1'b0;
         end
      endcase

      // saturating counters
      ill_cnt_in  = (res.illegal && ill_cnt_ff != acfp_pkg::CNT_MAX) ?
                    ill_cnt_ff + 32'd1 : ill_cnt_ff;
      viol_step   = (res.frame_lost && viol_cnt_ff != acfp_pkg::CNT_MAX) ?
                    viol_cnt_ff + 32'd1 : viol_cnt_ff;
      viol_cnt_in = (res.stack_leak && viol_step != acfp_pkg::CNT_MAX) ?
                    viol_step + 32'd1 : viol_step;
      res.violation_total = viol_cnt_in;
      res.illegal_total   = ill_cnt_in;
   end

   // table write port: clearing sweep or entry update
   assign tbl_we    = clearing || (exec_fire && upd);
   assign tbl_waddr = clearing ? clr_addr_ff : cur_idx_ff;
   assign tbl_wdata = clearing ? '0 : new_ent;

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[tbl_waddr] <= tbl_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_data_ff <= table_mem[in_idx];
      end
   end

   // current transaction
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_item_ff <= in_item;
         cur_idx_ff  <= in_idx;
      end
   end

   assign rsp_valid_in = exec_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acfp_pkg::BK_CLEAR;
         clr_addr_ff  <= '0;
         ovp_en_ff    <= 1'b0;
         origin_ff    <= '0;
         viol_cnt_ff  <= '0;
         ill_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ovp_en_ff <= csr_wr_data;
         end
         if (exec_fire) begin
            origin_ff   <= origin_in;
            viol_cnt_ff <= viol_cnt_in;
            ill_cnt_ff  <= ill_cnt_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // table read and write never share a cycle
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !tbl_we)
      else $error("table read collided with a write");

   // counters never run backwards
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (ill_cnt_ff >= $past(ill_cnt_ff) && viol_cnt_ff >= $past(viol_cnt_ff)))
      else $error("event counter decreased");

   // clearing sweep ends after the last entry
   assert property (@(posedge clock) disable iff (reset)
      (clearing && clr_addr_ff == IDX_LAST) |=> (state_ff == acfp_pkg::BK_IDLE))
      else $error("clearing sweep did not finish");

   // a fatal transaction leaves the table alone
   assert property (@(posedge clock) disable iff (reset)
      (exec_fire && res.fatal) |-> !tbl_we)
      else $error("fatal transaction wrote the table");

endmodule

`default_nettype wire

// File: rtl/activation_frame_port_checker_core.sv
// top level of the activation frame port checker
// a request passes front stage one, front stage two, the queue, the table read register and then the result register
// the back end takes one transaction at a time: it reads the table while idle and writes it while executing
// a four-entry queue lets the index front end run ahead of a stalled back end
// reset: synchronous; all TABLE_DEPTH entries (4096 by default) of the table are then cleared one entry a cycle,
// req_ready stays low during that sweep, csr writes are taken throughout
`default_nettype none

module activation_frame_port_checker_core #(
   parameter int TABLE_DEPTH = acfp_pkg::TABLE_DEPTH_DEF,
   parameter int QUEUE_DEPTH = acfp_pkg::QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_wr_en,
   input  wire                csr_wr_data,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire [3:0]          req_func,
   input  wire [31:0]         req_node,
   input  wire [47:0]         req_frame_pointer,
   input  wire [47:0]         req_stack_pointer,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic               rsp_no_alpha,
   output logic               rsp_illegal,
   output logic               rsp_frame_lost,
   output logic               rsp_stack_leak,
   output logic               rsp_overpop,
   output logic               rsp_alpha_while_live,
   output logic               rsp_fatal,
   output logic signed [47:0] rsp_frame_skew,
   output logic signed [47:0] rsp_depth,
   output logic [2:0]         rsp_prior_phase,
   output logic [31:0]        rsp_violation_total,
   output logic [31:0]        rsp_illegal_total
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int Q_W   = $bits(acfp_pkg::item_type) + IDX_W;

   acfp_pkg::item_type req_item;
   acfp_pkg::item_type front_item;
   logic [IDX_W-1:0]   front_idx;
   logic               front_valid;
   logic               front_ready;
   logic [Q_W-1:0]     q_wdata;
   logic [Q_W-1:0]     q_rdata;
   logic               q_valid;
   logic               q_ready;
   acfp_pkg::item_type back_item;
   logic [IDX_W-1:0]   back_idx;
   logic               table_ready;
   acfp_pkg::rsp_type  rsp;

   // request transaction payload
   always_comb begin
      req_item.func          = req_func;
      req_item.node          = req_node;
      req_item.frame_pointer = req_frame_pointer;
      req_item.stack_pointer = req_stack_pointer;
   end

   acfp_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (table_ready),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item),
      .out_idx   (front_idx)
   );

   assign q_wdata = {front_item, front_idx};

   acfp_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (q_wdata),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_rdata)
   );

   assign back_item = acfp_pkg::item_type'(q_rdata[Q_W-1:IDX_W]);
   assign back_idx  = q_rdata[IDX_W-1:0];

   acfp_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .table_ready (table_ready),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .in_item     (back_item),
      .in_idx      (back_idx),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   // result transaction payload
   assign rsp_no_alpha         = rsp.no_alpha;
   assign rsp_illegal          = rsp.illegal;
   assign rsp_frame_lost       = rsp.frame_lost;
   assign rsp_stack_leak       = rsp.stack_leak;
   assign rsp_overpop          = rsp.overpop;
   assign rsp_alpha_while_live = rsp.alpha_while_live;
   assign rsp_fatal            = rsp.fatal;
   assign rsp_frame_skew       = rsp.frame_skew;
   assign rsp_depth            = rsp.depth;
   assign rsp_prior_phase      = rsp.prior_phase;
   assign rsp_violation_total  = rsp.violation_total;
   assign rsp_illegal_total    = rsp.illegal_total;

endmodule

`default_nettype wire

// File: verif/activation_frame_port_checker_core_tb.sv
// self-checking testbench for the activation frame port checker core
`timescale 1ns / 1ps

module activation_frame_port_checker_core_tb;

   localparam int          HALF_PERIOD    = 5;
   localparam int          RESET_CYCLES   = 6;
   localparam int          TBL_DEPTH      = acfp_pkg::TABLE_DEPTH_DEF;
   localparam int          TBL_IDX_W      = $clog2(TBL_DEPTH);
   localparam int          MAX_GAP        = 18;
   localparam int          HOLD_CYCLES    = 120;
   localparam int          HOLD_AT        = 20;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          PHASE_ITEMS    = 130;
   localparam int          MAX_REPORTS    = 10;
   localparam int          RUN_LIMIT_NS   = 3_000_000;
   localparam int          NODE_POOL_SIZE = 8;
   localparam int          POOL_W         = $clog2(NODE_POOL_SIZE);

   // codes the package leaves unnamed
   localparam logic [3:0]  FUNC_FL_BETA     = acfp_pkg::FUNC_BETA + acfp_pkg::FL_OFFSET;
   localparam logic [3:0]  FUNC_FL_OMEGA    = acfp_pkg::FUNC_OMEGA + acfp_pkg::FL_OFFSET;
   localparam logic [3:0]  FUNC_UNKNOWN_HI  = 4'd15;

   // nodes that pairwise collide on table slots, plus the reset-owned node zero
   localparam logic [31:0] NODE_POOL [NODE_POOL_SIZE] = '{
      32'h0000_0000, 32'h0000_1000, 32'hFFFF_FFFF, 32'h0000_0FFF,
      32'h1234_5ABC, 32'h8000_0ABC, 32'h0000_0005, 32'h7FFF_F005
   };

   typedef struct {
      acfp_pkg::item_type ev;
      bit                 typed;
      acfp_pkg::rsp_type  want;
   } stim_row_type;

   // dut ports
   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               csr_wr_en         = 1'b0;
   logic               csr_wr_data       = 1'b0;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [3:0]         req_func          = '0;
   logic [31:0]        req_node          = '0;
   logic [47:0]        req_frame_pointer = '0;
   logic [47:0]        req_stack_pointer = '0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic               rsp_no_alpha;
   logic               rsp_illegal;
   logic               rsp_frame_lost;
   logic               rsp_stack_leak;
   logic               rsp_overpop;
   logic               rsp_alpha_while_live;
   logic               rsp_fatal;
   logic signed [47:0] rsp_frame_skew;
   logic signed [47:0] rsp_depth;
   logic [2:0]         rsp_prior_phase;
   logic [31:0]        rsp_violation_total;
   logic [31:0]        rsp_illegal_total;

   // shadow of the activation table and global state
   logic [31:0]         tag_tbl       [TBL_DEPTH];
   logic [47:0]         encl_tbl      [TBL_DEPTH];
   logic [47:0]         exp_frame_tbl [TBL_DEPTH];
   logic [47:0]         alpha_sp_tbl  [TBL_DEPTH];
   logic                live_tbl      [TBL_DEPTH];
   acfp_pkg::phase_type phase_tbl     [TBL_DEPTH];
   logic [47:0]         origin_sp;
   logic [31:0]         violation_cnt;
   logic [31:0]         illegal_cnt;
   logic                overpop_en;

   acfp_pkg::rsp_type  pending_checks [$];
   stim_row_type       directed_rows [$];

   // run bookkeeping
   bit                 fast_mode    = 1'b0;
   bit                 hold_request = 1'b0;
   int unsigned        items_sent;
   int unsigned        results_checked;
   int unsigned        mismatch_count;
   int unsigned        fatal_seen;
   int unsigned        violation_seen;
   int unsigned        holds_done;
   int unsigned        csr_writes;

   activation_frame_port_checker_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_node             (req_node),
      .req_frame_pointer    (req_frame_pointer),
      .req_stack_pointer    (req_stack_pointer),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_no_alpha         (rsp_no_alpha),
      .rsp_illegal          (rsp_illegal),
      .rsp_frame_lost       (rsp_frame_lost),
      .rsp_stack_leak       (rsp_stack_leak),
      .rsp_overpop          (rsp_overpop),
      .rsp_alpha_while_live (rsp_alpha_while_live),
      .rsp_fatal            (rsp_fatal),
      .rsp_frame_skew       (rsp_frame_skew),
      .rsp_depth            (rsp_depth),
      .rsp_prior_phase      (rsp_prior_phase),
      .rsp_violation_total  (rsp_violation_total),
      .rsp_illegal_total    (rsp_illegal_total)
   );

   // clock
   always #(HALF_PERIOD) clock = ~clock;

   // port check result for one event; updates the shadow table like the block does
   function automatic acfp_pkg::rsp_type predict_port_check(acfp_pkg::item_type ev);
      acfp_pkg::rsp_type   r;
      logic [TBL_IDX_W-1:0] idx;
      bit                  owned;
      bit                  frameless;
      logic [3:0]          kind;
      acfp_pkg::phase_type ph;
      logic [47:0]         ref_frame;
      logic [47:0]         alpha_sp;
      r         = '0;
      idx       = TBL_IDX_W'(ev.node % 32'(TBL_DEPTH));
      owned     = (tag_tbl[idx] == ev.node);
      ph        = phase_tbl[idx];
      frameless = (ev.func >= acfp_pkg::FUNC_FL_ALPHA) && (ev.func <= acfp_pkg::FUNC_FL_GAMMA);
      kind      = frameless ? ev.func - acfp_pkg::FL_OFFSET : ev.func;
      r.prior_phase = owned ? ph : acfp_pkg::PH_FRESH;
      r.depth       = (origin_sp != '0) ? origin_sp - ev.stack_pointer : '0;

      if (kind == acfp_pkg::FUNC_ORIGIN) begin
         origin_sp = ev.stack_pointer;
      end else if (kind == acfp_pkg::FUNC_ALPHA) begin
         // alpha always claims the slot, flagging a still-running owner
         r.alpha_while_live = owned && (ph == acfp_pkg::PH_LIVE ||
            ph == acfp_pkg::PH_SUSP || ph == acfp_pkg::PH_RESUMED);
         tag_tbl[idx]       = ev.node;
         encl_tbl[idx]      = ev.frame_pointer;
         exp_frame_tbl[idx] = frameless ? ev.frame_pointer :
                              ev.stack_pointer - acfp_pkg::FRAME_OFFSET;
         alpha_sp_tbl[idx]  = ev.stack_pointer;
         live_tbl[idx]      = 1'b1;
         phase_tbl[idx]     = acfp_pkg::PH_LIVE;
      end else if (kind == acfp_pkg::FUNC_BETA || kind == acfp_pkg::FUNC_GAMMA ||
                   kind == acfp_pkg::FUNC_OMEGA) begin
         if (!owned || !live_tbl[idx]) begin
            // no live activation here: slot untouched
            r.no_alpha = (kind == acfp_pkg::FUNC_BETA);
            if (kind == acfp_pkg::FUNC_GAMMA && (!owned || ph == acfp_pkg::PH_FRESH ||
                ph == acfp_pkg::PH_DEAD)) begin
               r.illegal = 1'b1;
               if (!frameless) r.fatal = 1'b1;
            end
         end else if (kind == acfp_pkg::FUNC_BETA) begin
            // beta: only from suspended, any frame loss aborts
            ref_frame = exp_frame_tbl[idx];
            if (ph != acfp_pkg::PH_SUSP) begin
               r.illegal = 1'b1;
               if (!frameless) r.fatal = 1'b1;
            end
            r.frame_skew = ev.frame_pointer - ref_frame;
            if (ev.frame_pointer != ref_frame) begin
               r.frame_lost = 1'b1;
               r.fatal      = 1'b1;
            end
            if (!r.fatal) phase_tbl[idx] = acfp_pkg::PH_RESUMED;
         end else if (kind == acfp_pkg::FUNC_GAMMA) begin
            // gamma: from live or resumed
            ref_frame = exp_frame_tbl[idx];
            if (ph != acfp_pkg::PH_LIVE && ph != acfp_pkg::PH_RESUMED) begin
               r.illegal = 1'b1;
               if (!frameless) r.fatal = 1'b1;
            end
            r.frame_skew = ev.frame_pointer - ref_frame;
            if (ev.frame_pointer != ref_frame) begin
               r.frame_lost = 1'b1;
               if (!frameless) r.fatal = 1'b1;
            end
            if (!r.fatal) phase_tbl[idx] = acfp_pkg::PH_SUSP;
         end else begin
            // omega: enclosing frame and stack balance
            ref_frame    = encl_tbl[idx];
            alpha_sp     = alpha_sp_tbl[idx];
            r.frame_skew = ev.frame_pointer - ref_frame;
            if (ev.frame_pointer != ref_frame) begin
               r.frame_lost = 1'b1;
               if (!frameless) r.fatal = 1'b1;
            end
            if (overpop_en && ev.stack_pointer > alpha_sp) r.overpop = 1'b1;
            if (ev.stack_pointer < alpha_sp) begin
               r.stack_leak = 1'b1;
               if (!frameless) r.fatal = 1'b1;
            end
            if (!r.fatal) begin
               live_tbl[idx]  = 1'b0;
               phase_tbl[idx] = acfp_pkg::PH_DEAD;
            end
         end
      end

      // saturating totals
      if (r.illegal && illegal_cnt != acfp_pkg::CNT_MAX) illegal_cnt++;
      if (r.frame_lost && violation_cnt != acfp_pkg::CNT_MAX) violation_cnt++;
      if (r.stack_leak && violation_cnt != acfp_pkg::CNT_MAX) violation_cnt++;
      r.violation_total = violation_cnt;
      r.illegal_total   = illegal_cnt;
      return r;
   endfunction

   // flag-only result for the hand-checked rows
   function automatic acfp_pkg::rsp_type flag_rsp(bit no_alpha, bit illegal, bit fatal,
                                                  logic [31:0] illegal_total);
      acfp_pkg::rsp_type r;
      r               = '0;
      r.no_alpha      = no_alpha;
      r.illegal       = illegal;
      r.fatal         = fatal;
      r.illegal_total = illegal_total;
      return r;
   endfunction

   function automatic void add_row(logic [3:0] func, logic [31:0] node, logic [47:0] fp,
                                   logic [47:0] sp, bit typed = 1'b0,
                                   acfp_pkg::rsp_type want = '0);
      stim_row_type row;
      row.ev.func          = func;
      row.ev.node          = node;
      row.ev.frame_pointer = fp;
      row.ev.stack_pointer = sp;
      row.typed            = typed;
      row.want             = want;
      directed_rows.push_back(row);
   endfunction

   // one request transaction, then queue its expected result
   task automatic send_item(acfp_pkg::item_type ev, bit typed = 1'b0,
                            acfp_pkg::rsp_type want = '0);
      int unsigned       gap;
      acfp_pkg::rsp_type expected;
      gap = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= ev.func;
      req_node          <= ev.node;
      req_frame_pointer <= ev.frame_pointer;
      req_stack_pointer <= ev.stack_pointer;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected = predict_port_check(ev);
      pending_checks.push_back(typed ? want : expected);
      items_sent++;
   endtask

   // stop offering and wait until every result is back
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_checks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_overpop(logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      overpop_en   = value;
      csr_writes++;
   endtask

   // mostly well-formed activations on a small colliding node set, the rest noise
   task automatic run_random_phase(int unsigned count, bit hold_once);
      acfp_pkg::item_type   ev;
      logic [TBL_IDX_W-1:0] idx;
      logic [POOL_W-1:0]    pick;
      bit                   frameless;
      logic [3:0]           kind;
      logic [47:0]          bump;
      for (int unsigned n = 0; n < count; n++) begin
         if (hold_once && n == HOLD_AT) hold_request = 1'b1;
         pick             = POOL_W'($urandom_range(0, NODE_POOL_SIZE - 1));
         ev.node          = NODE_POOL[pick];
         ev.frame_pointer = 48'({$urandom, $urandom});
         ev.stack_pointer = 48'({$urandom, $urandom});
         idx              = TBL_IDX_W'(ev.node % 32'(TBL_DEPTH));
         frameless        = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 3) == 0) begin
            // noise: any code, sometimes any node
            ev.func = 4'($urandom_range(acfp_pkg::FUNC_ORIGIN, FUNC_UNKNOWN_HI));
            if ($urandom_range(0, 1) == 1) ev.node = $urandom;
         end else begin
            if (tag_tbl[idx] == ev.node && live_tbl[idx]) begin
               // next legal port with the frames it should see
               if ($urandom_range(0, 3) == 0) kind = acfp_pkg::FUNC_OMEGA;
               else kind = (phase_tbl[idx] == acfp_pkg::PH_SUSP) ? acfp_pkg::FUNC_BETA :
                           acfp_pkg::FUNC_GAMMA;
               if (kind == acfp_pkg::FUNC_OMEGA) begin
                  bump = ($urandom_range(0, 2) == 0) ? 48'($urandom_range(1, 64)) : '0;
                  ev.frame_pointer = encl_tbl[idx];
                  ev.stack_pointer = alpha_sp_tbl[idx] + bump;
               end else begin
                  ev.frame_pointer = exp_frame_tbl[idx];
               end
               // occasional broken frame or leaked stack
               case ($urandom_range(0, 11))
                  0:       ev.frame_pointer = ev.frame_pointer + 48'($urandom_range(1, 255));
                  1:       ev.stack_pointer = ev.stack_pointer - 48'($urandom_range(1, 255));
                  default: ;
               endcase
            end else if ($urandom_range(0, 9) == 0) begin
               kind = acfp_pkg::FUNC_ORIGIN;
            end else begin
               kind = acfp_pkg::FUNC_ALPHA;
            end
            ev.func = (frameless && kind != acfp_pkg::FUNC_ORIGIN) ?
                      kind + acfp_pkg::FL_OFFSET : kind;
         end
         send_item(ev);
      end
   endtask

   function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch %s on result %0d: expected %h got %h",
                  field, results_checked, want, got);
   endfunction

   // result side: random stalls, one long hold-off on request
   initial begin : result_sink
      int unsigned       stall;
      acfp_pkg::rsp_type got;
      acfp_pkg::rsp_type want;
      wait (reset == 1'b0);
      forever begin
         stall = hold_request ? HOLD_CYCLES : (fast_mode ? 0 : $urandom_range(0, MAX_GAP));
         if (hold_request) begin
            hold_request = 1'b0;
            holds_done++;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);

         // transaction taken at this edge
         got.no_alpha         = rsp_no_alpha;
         got.illegal          = rsp_illegal;
         got.frame_lost       = rsp_frame_lost;
         got.stack_leak       = rsp_stack_leak;
         got.overpop          = rsp_overpop;
         got.alpha_while_live = rsp_alpha_while_live;
         got.fatal            = rsp_fatal;
         got.frame_skew       = rsp_frame_skew;
         got.depth            = rsp_depth;
         got.prior_phase      = acfp_pkg::phase_type'(rsp_prior_phase);
         got.violation_total  = rsp_violation_total;
         got.illegal_total    = rsp_illegal_total;

         if (pending_checks.size() == 0) begin
            note_mismatch("unexpected result", '0, 64'(got.illegal_total));
         end else begin
            want = pending_checks.pop_front();
            if (got.no_alpha !== want.no_alpha)
               note_mismatch("no_alpha", 64'(want.no_alpha), 64'(got.no_alpha));
            if (got.illegal !== want.illegal)
               note_mismatch("illegal", 64'(want.illegal), 64'(got.illegal));
            if (got.frame_lost !== want.frame_lost)
               note_mismatch("frame_lost", 64'(want.frame_lost), 64'(got.frame_lost));
            if (got.stack_leak !== want.stack_leak)
               note_mismatch("stack_leak", 64'(want.stack_leak), 64'(got.stack_leak));
            if (got.overpop !== want.overpop)
               note_mismatch("overpop", 64'(want.overpop), 64'(got.overpop));
            if (got.alpha_while_live !== want.alpha_while_live)
               note_mismatch("alpha_while_live", 64'(want.alpha_while_live),
                             64'(got.alpha_while_live));
            if (got.fatal !== want.fatal)
               note_mismatch("fatal", 64'(want.fatal), 64'(got.fatal));
            if (got.frame_skew !== want.frame_skew)
               note_mismatch("frame_skew", 64'(want.frame_skew), 64'(got.frame_skew));
            if (got.depth !== want.depth)
               note_mismatch("depth", 64'(want.depth), 64'(got.depth));
            if (got.prior_phase !== want.prior_phase)
               note_mismatch("prior_phase", 64'(want.prior_phase), 64'(got.prior_phase));
            if (got.violation_total !== want.violation_total)
               note_mismatch("violation_total", 64'(want.violation_total),
                             64'(got.violation_total));
            if (got.illegal_total !== want.illegal_total)
               note_mismatch("illegal_total", 64'(want.illegal_total), 64'(got.illegal_total));
            if (want.fatal) fatal_seen++;
            if (want.frame_lost || want.stack_leak) violation_seen++;
         end
         results_checked++;
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      tag_tbl       = '{default: '0};
      encl_tbl      = '{default: '0};
      exp_frame_tbl = '{default: '0};
      alpha_sp_tbl  = '{default: '0};
      live_tbl      = '{default: 1'b0};
      phase_tbl     = '{default: acfp_pkg::PH_FRESH};
      origin_sp     = '0;
      violation_cnt = '0;
      illegal_cnt   = '0;
      overpop_en    = 1'b0;

      // ports before any origin or alpha: flags read off directly
      add_row(acfp_pkg::FUNC_BETA,     32'd5, '0, '0, 1'b1,
              flag_rsp(1'b1, 1'b0, 1'b0, 32'd0));
      add_row(acfp_pkg::FUNC_GAMMA,    32'd5, '0, '0, 1'b1,
              flag_rsp(1'b0, 1'b1, 1'b1, 32'd1));
      add_row(acfp_pkg::FUNC_FL_GAMMA, 32'd5, '0, '0, 1'b1,
              flag_rsp(1'b0, 1'b1, 1'b0, 32'd2));
      add_row(acfp_pkg::FUNC_OMEGA,    32'd5, '0, '0, 1'b1,
              flag_rsp(1'b0, 1'b0, 1'b0, 32'd2));
      // node zero owns its slot after reset but is fresh
      add_row(acfp_pkg::FUNC_GAMMA,    32'd0, '0, '0, 1'b1,
              flag_rsp(1'b0, 1'b1, 1'b1, 32'd3));
      add_row(acfp_pkg::FUNC_ORIGIN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
              1'b1, flag_rsp(1'b0, 1'b0, 1'b0, 32'd3));
      // full framed activation at the top node, with frame loss and re-entry
      add_row(acfp_pkg::FUNC_ALPHA,    32'hFFFF_FFFF, 48'h1000, 48'h2000);
      add_row(acfp_pkg::FUNC_GAMMA,    32'hFFFF_FFFF, 48'h1FF8, 48'h2000);
      add_row(acfp_pkg::FUNC_BETA,     32'hFFFF_FFFF, 48'h1FF8, 48'h2000);
      add_row(acfp_pkg::FUNC_GAMMA,    32'hFFFF_FFFF, 48'h1FF8, 48'h2000);
      add_row(acfp_pkg::FUNC_BETA,     32'hFFFF_FFFF, 48'h2000, 48'h2000);
      add_row(acfp_pkg::FUNC_BETA,     32'hFFFF_FFFF, 48'h1FF8, 48'h2000);
      add_row(acfp_pkg::FUNC_BETA,     32'hFFFF_FFFF, 48'h1FF8, 48'h2000);
      add_row(acfp_pkg::FUNC_ALPHA,    32'hFFFF_FFFF, 48'h1000, 48'h2000);
      add_row(acfp_pkg::FUNC_OMEGA,    32'hFFFF_FFFF, 48'h1000, 48'h3000);
      add_row(acfp_pkg::FUNC_GAMMA,    32'hFFFF_FFFF, 48'h1000, 48'h2000);
      add_row(acfp_pkg::FUNC_BETA,     32'hFFFF_FFFF, 48'h1000, 48'h2000);
      // frameless activation stealing the same slot
      add_row(acfp_pkg::FUNC_FL_ALPHA, 32'h0000_1FFF, 48'h5000, 48'h0100);
      add_row(acfp_pkg::FUNC_FL_GAMMA, 32'h0000_1FFF, 48'h5001, 48'h0000);
      add_row(FUNC_FL_BETA,            32'h0000_1FFF, 48'h5000, 48'h0000);
      add_row(acfp_pkg::FUNC_GAMMA,    32'hFFFF_FFFF, 48'h1FF8, 48'h2000);
      add_row(FUNC_FL_OMEGA,           32'h0000_1FFF, 48'h0000, 48'h0000);
      add_row(acfp_pkg::FUNC_OMEGA,    32'h0000_1FFF, 48'h5000, 48'h0100);
      add_row(FUNC_UNKNOWN_HI,         32'd5, 48'hFFFF_FFFF_FFFF, 48'h0);
      // expected frame wraps below zero
      add_row(acfp_pkg::FUNC_ALPHA,    32'd7, 48'h0, 48'h0);
      add_row(acfp_pkg::FUNC_GAMMA,    32'd7, 48'hFFFF_FFFF_FFF8, 48'h0);
      add_row(acfp_pkg::FUNC_OMEGA,    32'd7, 48'h1, 48'h0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_overpop(1'b1);

      foreach (directed_rows[i])
         send_item(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

      // random phases across both overpop settings
      wait_for_idle();
      write_overpop(1'b0);
      run_random_phase(PHASE_ITEMS, 1'b0);

      // back-to-back with one long result hold-off to back up the input
      wait_for_idle();
      write_overpop(1'b1);
      fast_mode = 1'b1;
      run_random_phase(PHASE_ITEMS, 1'b1);
      fast_mode = 1'b0;

      wait_for_idle();
      write_overpop(1'b0);
      run_random_phase(PHASE_ITEMS, 1'b0);

      wait_for_idle();
      write_overpop(1'b1);
      run_random_phase(PHASE_ITEMS, 1'b0);

      wait_for_idle();
      $display("%0d port events checked across %0d overpop csr writes, %0d long hold-offs",
               results_checked, csr_writes, holds_done);
      $display("%0d fatal events, %0d frame or stack violations, %0d mismatches",
               fatal_seen, violation_seen, mismatch_count);
      if (mismatch_count == 0 && pending_checks.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("timeout after %0d items sent, %0d results", items_sent, results_checked);
      $display("Regression FAIL");
      $finish;
   end

endmodule
